// ===== rtl/rce_pkg.sv =====
// ----------------------------------------------------------------------------
// rce_pkg
// Shared constants, codes and the control bundle of the closure cell chain.
// ----------------------------------------------------------------------------
package rce_pkg;

    localparam int ROW_LIMIT     = 16;
    localparam int MAX_NODES_DEF = 16;
    localparam int NODE_W        = 5;
    localparam int CMD_W         = 2;
    localparam int KIND_W        = 2;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 5;
    localparam int ROW_IDX_W     = 4;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_REFL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYMM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRANS = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_NODE_COUNT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CLOSURE_KIND = 2'd1;

    // control broadcast to every cell; vectors sized for the widest chain
    typedef struct packed {
        logic                     rotate;
        logic                     load_clo;
        logic                     warshall_en;
        logic                     clear;
        logic                     add_en;
        logic [NODE_W-1:0]        add_row;
        logic [ROW_IDX_W-1:0]     add_col;
        logic [NODE_W-1:0]        n_eff;
        logic [ROW_LIMIT-1:0]     mask;
        logic [KIND_W-1:0]        kind;
        logic                     piv_live;
        logic [ROW_IDX_W-1:0]     piv_idx;
        logic [ROW_LIMIT-1:0]     piv_m;
        logic [ROW_LIMIT-1:0]     piv_clo;
    } rce_ctl_t;

endpackage

// ===== rtl/rce_cell.sv =====
// ----------------------------------------------------------------------------
// rce_cell
// One row of the relation and of its closure; rotates to its neighbor.
// ----------------------------------------------------------------------------
module rce_cell import rce_pkg::*; #(
    parameter int ROWS = MAX_NODES_DEF,
    parameter int IW   = 4,
    parameter int POS  = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  rce_ctl_t        ctl,
    input  logic [ROWS-1:0] nb_rel,
    input  logic [ROWS-1:0] nb_clo,
    input  logic [IW-1:0]   nb_idx,
    input  logic [ROWS-1:0] col_in,
    output logic [ROWS-1:0] rel_o,
    output logic [ROWS-1:0] clo_o,
    output logic [ROWS-1:0] clo_fwd_o,
    output logic [IW-1:0]   idx_o,
    output logic [ROWS-1:0] m_o,
    output logic            live_o,
    output logic            refl_ok_o,
    output logic            symm_ok_o,
    output logic            fail_o
);

    logic [ROWS-1:0] rel_reg, rel_next;
    logic [ROWS-1:0] clo_reg, clo_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [ROWS-1:0] mask;
    logic [ROWS-1:0] m;
    logic [ROWS-1:0] upd;
    logic [ROWS-1:0] self_bit;
    logic [IW-1:0]   piv_idx;
    logic            live;

    assign mask     = ctl.mask[ROWS-1:0];
    assign piv_idx  = ctl.piv_idx[IW-1:0];
    assign live     = NODE_W'(idx_reg) < ctl.n_eff;
    assign m        = live ? (rel_reg & mask) : '0;
    assign self_bit = live ? (ROWS'(1) << idx_reg) : '0;

    // Warshall step against the pivot row held in cell 0
    assign upd = (ctl.warshall_en && ctl.piv_live && clo_reg[piv_idx])
               ? (clo_reg | ctl.piv_clo[ROWS-1:0]) : clo_reg;

    always_comb begin
        rel_next = rel_reg;
        clo_next = clo_reg;
        idx_next = idx_reg;
        if (ctl.rotate) begin
            rel_next = nb_rel;
            clo_next = nb_clo;
            idx_next = nb_idx;
        end else if (ctl.load_clo) begin
            case (ctl.kind)
                KIND_REFL: clo_next = m | self_bit;
                KIND_SYMM: clo_next = m | col_in;
                default:   clo_next = m;
            endcase
        end else if (ctl.clear) begin
            rel_next = '0;
        end else if (ctl.add_en && ctl.add_row == NODE_W'(idx_reg)) begin
            rel_next = rel_reg | (ROWS'(1) << ctl.add_col);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_reg <= '0;
            idx_reg <= IW'(POS);
        end else begin
            rel_reg <= rel_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        clo_reg <= clo_next;
    end

    assign rel_o     = rel_reg;
    assign clo_o     = clo_reg;
    assign clo_fwd_o = upd;
    assign idx_o     = idx_reg;
    assign m_o       = m;
    assign live_o    = live;
    assign refl_ok_o = !live || m[idx_reg];
    assign symm_ok_o = (m == col_in);
    assign fail_o    = ctl.piv_live && live && m[piv_idx]
                    && ((ctl.piv_m[ROWS-1:0] & ~m) != '0);

endmodule

// ===== rtl/relation_closure_engine_top.sv =====
// ----------------------------------------------------------------------------
// relation_closure_engine_top
// Relation store and closure engine built as a rotating ring of row cells.
// ----------------------------------------------------------------------------
// Clear and add words are taken back to back.
// Compute: a setup state (ST_PREP), then ROWS ring rotations for the Warshall pass and
// the transitive check, then one result word per row (n words), then ROWS-n
// rotations that bring the ring home; ROWS = min(MAX_NODES, 16).
// First result word is valid in ST_EMIT, after ST_PREP and the ST_PASS rotations.
// Reset (aresetn low, synchronous) empties the relation, sets node_count 16
// and closure_kind 2.
module relation_closure_engine_top import rce_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // from_node[4:0], to_node[9:5]
    input  logic [CMD_W-1:0]      s_tuser,   // command[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // row_index[3:0], relation_row[19:4], added_row[35:20], is_reflexive[36],
    // is_symmetric[37], is_transitive[38]
    output logic [39:0]           m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int ROWS = (MAX_NODES < ROW_LIMIT) ? MAX_NODES : ROW_LIMIT;
    localparam int IW   = $clog2(ROWS);
    localparam int CW   = $clog2(ROWS + 1);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_PREP    = 5'b00010,
        ST_PASS    = 5'b00100,
        ST_EMIT    = 5'b01000,
        ST_RESTORE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [NODE_W-1:0]   node_count_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic                refl_reg, refl_next;
    logic                symm_reg, symm_next;
    logic                trans_reg, trans_next;

    logic [NODE_W-1:0]   n_eff;
    logic [ROW_LIMIT-1:0] mask;
    logic [NODE_W-1:0]   from_node, to_node;
    logic                pair_ok;
    logic                s_acc;
    logic                last_row;
    rce_ctl_t            ctl;

    logic [ROWS-1:0]     rel_o   [ROWS];
    logic [ROWS-1:0]     clo_o   [ROWS];
    logic [ROWS-1:0]     clo_fwd [ROWS];
    logic [ROWS-1:0]     m_o     [ROWS];
    logic [ROWS-1:0]     col     [ROWS];
    logic [IW-1:0]       idx_o   [ROWS];
    logic [ROWS-1:0]     live_v, refl_v, symm_v, fail_v, any_v;
    logic [ROWS-1:0]     added;

    assign n_eff = (node_count_reg > NODE_W'(ROWS)) ? NODE_W'(ROWS) : node_count_reg;

    always_comb begin
        mask = '0;
        for (int j = 0; j < ROWS; j++) begin
            mask[j] = NODE_W'(j) < n_eff;
        end
    end

    always_comb begin
        for (int c = 0; c < ROWS; c++) begin
            for (int r = 0; r < ROWS; r++) begin
                col[c][r] = m_o[r][c];
            end
        end
    end

    assign from_node = s_tdata[4:0];
    assign to_node   = s_tdata[9:5];
    assign pair_ok   = (from_node != '0) && (from_node <= n_eff)
                    && (to_node != '0) && (to_node <= n_eff);
    assign s_acc     = s_tvalid && s_tready;
    assign last_row  = (NODE_W'(cnt_reg) + NODE_W'(1)) == n_eff;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_W'(16);
            kind_reg       <= KIND_TRANS;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_NODE_COUNT:   node_count_reg <= cfg_wr_data;
                REG_CLOSURE_KIND: kind_reg       <= cfg_wr_data[KIND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        refl_next  = refl_reg;
        symm_next  = symm_reg;
        trans_next = trans_reg;

        ctl             = '0;
        ctl.add_row     = from_node - NODE_W'(1);
        ctl.add_col     = ROW_IDX_W'(to_node - NODE_W'(1));
        ctl.n_eff       = n_eff;
        ctl.mask        = mask;
        ctl.kind        = kind_reg;
        ctl.piv_live    = live_v[0];
        ctl.piv_idx     = ROW_IDX_W'(idx_o[0]);
        ctl.piv_m       = ROW_LIMIT'(m_o[0]);
        ctl.piv_clo     = ROW_LIMIT'(clo_o[0]);

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        CMD_CLEAR:   ctl.clear  = 1'b1;
                        CMD_ADD:     ctl.add_en = pair_ok;
                        CMD_COMPUTE: begin
                            if (n_eff != '0) begin
                                state_next = ST_PREP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREP: begin
                ctl.load_clo = 1'b1;
                refl_next    = &refl_v;
                symm_next    = (&symm_v) && (|any_v);
                trans_next   = |any_v;
                cnt_next     = '0;
                state_next   = ST_PASS;
            end
            ST_PASS: begin
                ctl.rotate      = 1'b1;
                ctl.warshall_en = (kind_reg == KIND_TRANS);
                trans_next      = trans_reg && !(|fail_v);
                if (cnt_reg == CW'(ROWS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    ctl.rotate = 1'b1;
                    if (last_row && n_eff == NODE_W'(ROWS)) begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + CW'(1);
                        if (last_row) begin
                            state_next = ST_RESTORE;
                        end
                    end
                end
            end
            ST_RESTORE: begin
                ctl.rotate = 1'b1;
                if (cnt_reg == CW'(ROWS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        refl_reg  <= refl_next;
        symm_reg  <= symm_next;
        trans_reg <= trans_next;
    end

    for (genvar c = 0; c < ROWS; c++) begin : g_cell
        rce_cell #(
            .ROWS (ROWS),
            .IW   (IW),
            .POS  (c)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .nb_rel    (rel_o[(c + 1) % ROWS]),
            .nb_clo    (clo_fwd[(c + 1) % ROWS]),
            .nb_idx    (idx_o[(c + 1) % ROWS]),
            .col_in    (col[c]),
            .rel_o     (rel_o[c]),
            .clo_o     (clo_o[c]),
            .clo_fwd_o (clo_fwd[c]),
            .idx_o     (idx_o[c]),
            .m_o       (m_o[c]),
            .live_o    (live_v[c]),
            .refl_ok_o (refl_v[c]),
            .symm_ok_o (symm_v[c]),
            .fail_o    (fail_v[c])
        );
        assign any_v[c] = |m_o[c];
    end

    assign added = clo_o[0] & mask[ROWS-1:0] & ~m_o[0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = (state_reg == ST_EMIT) && last_row;
    assign m_tdata  = {1'b0, trans_reg, symm_reg, refl_reg,
                       ROW_LIMIT'(added), ROW_LIMIT'(m_o[0]), ROW_IDX_W'(idx_o[0])};

endmodule
